>>> sv/i64acc_pkg.sv
package i64acc_pkg;

  localparam int unsigned DATA_W    = 64;
  localparam int unsigned OPC_W     = 4;
  localparam int unsigned ERR_W     = 2;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned SHIFT_MAX = 63;

  typedef enum logic [OPC_W-1:0] {
    OP_LOAD = 4'd0,
    OP_ADD  = 4'd1,
    OP_SUB  = 4'd2,
    OP_MUL  = 4'd3,
    OP_DIV  = 4'd4,
    OP_MOD  = 4'd5,
    OP_AND  = 4'd6,
    OP_OR   = 4'd7,
    OP_XOR  = 4'd8,
    OP_NOT  = 4'd9,
    OP_SHL  = 4'd10,
    OP_SHR  = 4'd11
  } opcode_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK          = 2'd0,
    ERR_DIV_ZERO    = 2'd1,
    ERR_SHIFT_RANGE = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    MD_MUL = 2'd0,
    MD_DIV = 2'd1,
    MD_MOD = 2'd2
  } md_op_t;

  typedef struct packed {
    logic   start;
    logic   ack;
    md_op_t op;
  } md_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_resp_t;

endpackage

>>> sv/i64acc_if.sv
interface i64acc_in_if import i64acc_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [OPC_W-1:0]         opcode;
  logic signed [DATA_W-1:0] operand;

  modport source (output valid, output opcode, output operand, input ready);
  modport sink   (input valid, input opcode, input operand, output ready);
endinterface

interface i64acc_out_if import i64acc_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic [ERR_W-1:0]         error;

  modport source (output valid, output value, output error, input ready);
  modport sink   (input valid, input value, input error, output ready);
endinterface

>>> sv/int64_accumulator_alu.sv
// 64-bit signed accumulator ALU. Each input word carries an opcode and an operand and
// returns exactly one output word: the accumulator after the operation and an error code
// (divide or remainder by zero, or shift amount above 63, leave the accumulator as it was).
// For load, add, subtract, the logic operations and the shifts the output word is valid on
// the cycle after the input word is taken. Multiply, divide and remainder run on a shared
// 65-bit adder under a small sequencer, one multiplier bit or one quotient bit per pass,
// 64 passes plus one sign-fix pass; their output word is registered after the sign-fix
// pass and the done state, once the output register is free, and no new input word is
// taken meanwhile. Divide and remainder by zero skip the sequencer. A new input word is
// taken only while the output register is empty or its word is taken on that same cycle,
// and never while a multiply or divide is in progress.
module int64_accumulator_alu import i64acc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  i64acc_in_if.sink    in_ch,
  i64acc_out_if.source out_ch
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } top_state_t;

  top_state_t        st_r, st_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  err_t              out_error_r, out_error_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              out_free, accept;
  logic [DATA_W-1:0] opnd, alu_val;
  err_t              alu_err;
  logic              eng_need;
  md_op_t            eng_op;
  md_req_t           md_req;
  md_resp_t          md_resp;
  logic [DATA_W-1:0] md_result;
  logic              shift_bad;

  assign opnd      = in_ch.operand;
  assign shift_bad = (opnd > DATA_W'(SHIFT_MAX));

  // Output register is free when empty or being drained this cycle.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (st_r == ST_IDLE) && out_free;
  assign accept      = in_ch.valid && in_ch.ready;

  // Combinational datapath; multiply and nonzero divide or remainder go to the sequencer.
  always_comb begin
    alu_val  = acc_r;
    alu_err  = ERR_OK;
    eng_need = 1'b0;
    eng_op   = MD_MUL;
    case (in_ch.opcode)
      OP_LOAD: alu_val = opnd;
      OP_ADD:  alu_val = acc_r + opnd;
      OP_SUB:  alu_val = acc_r - opnd;
      OP_AND:  alu_val = acc_r & opnd;
      OP_OR:   alu_val = acc_r | opnd;
      OP_XOR:  alu_val = acc_r ^ opnd;
      OP_NOT:  alu_val = ~acc_r;
      OP_MUL: begin
        eng_need = 1'b1;
      end
      OP_DIV, OP_MOD: begin
        eng_op = (in_ch.opcode == OP_DIV) ? MD_DIV : MD_MOD;
        if (opnd == '0) begin
          alu_err = ERR_DIV_ZERO;
        end else begin
          eng_need = 1'b1;
        end
      end
      OP_SHL: begin
        if (shift_bad) alu_err = ERR_SHIFT_RANGE;
        else           alu_val = acc_r << opnd[CNT_W-1:0];
      end
      OP_SHR: begin
        if (shift_bad) alu_err = ERR_SHIFT_RANGE;
        else           alu_val = acc_r >> opnd[CNT_W-1:0];
      end
      default: begin
        // unused opcodes hold the accumulator
      end
    endcase
  end

  assign md_req.start = accept && eng_need;
  assign md_req.op    = eng_op;
  assign md_req.ack   = (st_r == ST_BUSY) && md_resp.done && out_free;

  i64acc_muldiv u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (md_req),
    .a      (acc_r),
    .b      (opnd),
    .resp   (md_resp),
    .result (md_result)
  );

  always_comb begin
    st_nxt        = st_r;
    acc_nxt       = acc_r;
    out_value_nxt = out_value_r;
    out_error_nxt = out_error_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          if (eng_need) begin
            st_nxt = ST_BUSY;
          end else begin
            acc_nxt       = alu_val;
            out_value_nxt = alu_val;
            out_error_nxt = alu_err;
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_BUSY: begin
        // hold the sequencer result until the output register frees up
        if (md_req.ack) begin
          acc_nxt       = md_result;
          out_value_nxt = md_result;
          out_error_nxt = ERR_OK;
          out_valid_nxt = 1'b1;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_error_r <= out_error_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.value = out_value_r;
  assign out_ch.error = out_error_r;

  a_out_tracks_acc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> out_value_r == acc_r)
    else $error("output word does not match accumulator");

  a_engine_busy: assert property (@(posedge clk) disable iff (!rst_n)
    md_req.start |=> (st_r == ST_BUSY && md_resp.busy))
    else $error("sequencer start did not enter busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=>
      (out_valid_r && $stable(out_value_r) && $stable(out_error_r)))
    else $error("output word changed while stalled");

endmodule

>>> sv/i64acc_muldiv.sv
module i64acc_muldiv import i64acc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  md_req_t           req,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output md_resp_t          resp,
  output logic [DATA_W-1:0] result
);

  typedef enum logic [4:0] {
    MD_IDLE = 5'b00001,
    MD_RMUL = 5'b00010,
    MD_RDIV = 5'b00100,
    MD_FIX  = 5'b01000,
    MD_DONE = 5'b10000
  } md_state_t;

  md_state_t         st_r, st_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] x_r, x_nxt;    // multiplicand, or dividend shifting into quotient
  logic [DATA_W-1:0] y_r, y_nxt;    // multiplier, or divisor magnitude
  logic [DATA_W-1:0] p_r, p_nxt;    // product, or partial remainder
  logic [DATA_W-1:0] result_r, result_nxt;
  logic              neg_r, neg_nxt;
  md_op_t            op_r, op_nxt;

  logic [DATA_W:0]   add_a, add_b, add_sum;
  logic              add_ci;
  logic [DATA_W-1:0] mul_addend, fix_val, a_mag, b_mag;

  assign mul_addend = y_r[0] ? x_r : {DATA_W{1'b0}};
  assign fix_val    = (op_r == MD_DIV) ? x_r : p_r;
  assign a_mag      = a[DATA_W-1] ? (~a + 1'b1) : a;
  assign b_mag      = b[DATA_W-1] ? (~b + 1'b1) : b;

  // Shared adder: accumulate partial products, trial-subtract the divisor, fix the sign.
  always_comb begin
    add_a  = '0;
    add_b  = '0;
    add_ci = 1'b0;
    case (st_r)
      MD_RMUL: begin
        add_a = {1'b0, p_r};
        add_b = {1'b0, mul_addend};
      end
      MD_RDIV: begin
        add_a  = {p_r, x_r[DATA_W-1]};
        add_b  = ~{1'b0, y_r};
        add_ci = 1'b1;
      end
      MD_FIX: begin
        add_b  = ~{1'b0, fix_val};
        add_ci = 1'b1;
      end
      default: begin
      end
    endcase
    add_sum = add_a + add_b + {{DATA_W{1'b0}}, add_ci};
  end

  always_comb begin
    st_nxt     = st_r;
    cnt_nxt    = cnt_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    p_nxt      = p_r;
    neg_nxt    = neg_r;
    op_nxt     = op_r;
    result_nxt = result_r;
    case (st_r)
      MD_IDLE: begin
        if (req.start) begin
          op_nxt  = req.op;
          cnt_nxt = '1;
          p_nxt   = '0;
          if (req.op == MD_MUL) begin
            x_nxt   = a;
            y_nxt   = b;
            neg_nxt = 1'b0;
            st_nxt  = MD_RMUL;
          end else begin
            x_nxt   = a_mag;
            y_nxt   = b_mag;
            neg_nxt = (req.op == MD_DIV) ? (a[DATA_W-1] ^ b[DATA_W-1]) : a[DATA_W-1];
            st_nxt  = MD_RDIV;
          end
        end
      end
      MD_RMUL: begin
        if (y_r[0]) begin
          p_nxt = add_sum[DATA_W-1:0];
        end
        x_nxt   = {x_r[DATA_W-2:0], 1'b0};
        y_nxt   = {1'b0, y_r[DATA_W-1:1]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          st_nxt = MD_FIX;
        end
      end
      MD_RDIV: begin
        if (!add_sum[DATA_W]) begin
          p_nxt = add_sum[DATA_W-1:0];
          x_nxt = {x_r[DATA_W-2:0], 1'b1};
        end else begin
          p_nxt = {p_r[DATA_W-2:0], x_r[DATA_W-1]};
          x_nxt = {x_r[DATA_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          st_nxt = MD_FIX;
        end
      end
      MD_FIX: begin
        result_nxt = neg_r ? add_sum[DATA_W-1:0] : fix_val;
        st_nxt     = MD_DONE;
      end
      MD_DONE: begin
        if (req.ack) begin
          st_nxt = MD_IDLE;
        end
      end
      default: begin
        st_nxt = MD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= MD_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    p_r      <= p_nxt;
    neg_r    <= neg_nxt;
    op_r     <= op_nxt;
    result_r <= result_nxt;
  end

  assign resp.busy = (st_r != MD_IDLE);
  assign resp.done = (st_r == MD_DONE);
  assign result    = result_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> st_r == MD_IDLE)
    else $error("muldiv started while busy");

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (req.start && st_r == MD_IDLE) |=> (st_r == MD_RMUL || st_r == MD_RDIV))
    else $error("muldiv did not enter an iteration state");

  a_last_pass: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == MD_RMUL || st_r == MD_RDIV) && cnt_r == '0) |=> st_r == MD_FIX)
    else $error("muldiv missed the sign fix after the last pass");

endmodule
